// ===== rtl/swcc_pkg.sv =====
// ----------------------------------------------------------------------------
// swcc_pkg
// Shared types, constants and helpers for the synced wall clock calendar.
// ----------------------------------------------------------------------------
package swcc_pkg;

  // field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned DszW    = 20;
  localparam int unsigned TodW    = 17;
  localparam int unsigned MsW     = 12;
  localparam int unsigned DivCntW = 5;

  // calendar constants
  localparam logic [TodW-1:0]  SecsPerDay      = 17'd86400;
  localparam logic [MsW-1:0]   SecsPerHour     = 12'd3600;
  localparam logic [MinW-1:0]  SecsPerMin      = 6'd60;
  localparam logic [DszW-1:0]  DaysToUnixEpoch = 20'd719528;
  localparam logic [YearW-1:0] FirstYear       = 12'd1970;
  localparam logic [6:0]       FirstYearMod100 = 7'd70;
  localparam logic [8:0]       FirstYearMod400 = 9'd370;
  localparam logic [8:0]       DaysLeapYear    = 9'd366;
  localparam logic [8:0]       DaysCommonYear  = 9'd365;
  localparam logic [WordW-1:0] FreqReset       = 32'd1000;
  localparam logic [DivCntW-1:0] DivLastStep   = 5'd31;

  // reciprocals for exact division once the power-of-two factor is shifted off
  // t >> 7 by 675, scaled by 2^35
  localparam logic [25:0]      DayRecip        = 26'd50903317;
  // tod >> 4 by 225, scaled by 2^21
  localparam logic [13:0]      HourRecip       = 14'd9321;
  // seconds of the hour >> 2 by 15, scaled by 2^14
  localparam logic [10:0]      MinRecip        = 11'd1093;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_START,
    ST_SEC_RUN,
    ST_T_CAP,
    ST_DAY_QUO,
    ST_DAY_REM,
    ST_HOUR_QUO,
    ST_HOUR_REM,
    ST_MIN_QUO,
    ST_MIN_REM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } swcc_state_e;

  // which time split result gets captured
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_T,
    CAP_DAY_Q,
    CAP_DAY_R,
    CAP_HOUR_Q,
    CAP_HOUR_R,
    CAP_MIN_Q,
    CAP_MIN_R
  } cap_e;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    logic     div_step;
    cap_e     cap;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_done;
    logic month_done;
  } sts_t;

  // length of month m (0 = january)
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1:                             len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:          len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/swcc_ifs.sv =====
// ----------------------------------------------------------------------------
// swcc_ifs
// Valid/ready channel interfaces: item input, result output, configuration.
// ----------------------------------------------------------------------------

// item channel
interface swcc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] epoch_seconds;
  logic [31:0] tick_now;

  modport source(output valid, output func, output epoch_seconds, output tick_now,
                 input ready);
  modport sink(input valid, input func, input epoch_seconds, input tick_now,
               output ready);
endinterface

// result channel
interface swcc_out_if;
  logic        valid;
  logic        ready;
  logic        is_synced;
  logic [31:0] unix_seconds;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [19:0] days_since_year_zero;
  logic [16:0] seconds_of_day;

  modport source(output valid, output is_synced, output unix_seconds, output year,
                 output month, output day, output hour, output minute, output second,
                 output days_since_year_zero, output seconds_of_day, input ready);
  modport sink(input valid, input is_synced, input unix_seconds, input year,
               input month, input day, input hour, input minute, input second,
               input days_since_year_zero, input seconds_of_day, output ready);
endinterface

// tick frequency write channel
interface swcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/swcc_datapath.sv =====
// ----------------------------------------------------------------------------
// swcc_datapath
// Sync state, radix-2 divider for elapsed ticks, reciprocal time split,
// year and month walkers, result register.
// ----------------------------------------------------------------------------
module swcc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  swcc_in_if.sink             in_i,
  swcc_cfg_if.sink            cfg_i,
  swcc_out_if.source          out_o,
  input  swcc_pkg::cmd_t      cmd_i,
  output swcc_pkg::sts_t      sts_o
);

  // sync state and configuration
  logic [31:0] freq_q;
  logic [31:0] epoch_q;
  logic [31:0] tick_sync_q;
  logic        synced_q;
  logic [31:0] tick_now_q;

  // divider
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvsr_q, dvsr_d;
  logic [swcc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] dividend;

  // time split by constant reciprocals
  logic [50:0]                 day_prod;
  logic [31:0]                 day_back;
  logic [31:0]                 day_rem;
  logic [25:0]                 hour_prod;
  logic [swcc_pkg::TodW-1:0]   hour_back;
  logic [swcc_pkg::TodW-1:0]   hour_rem;
  logic [19:0]                 min_prod;
  logic [swcc_pkg::MsW-1:0]    min_back;
  logic [swcc_pkg::MsW-1:0]    min_rem;

  // calendar working registers
  logic [31:0] t_q;
  logic [swcc_pkg::DaysW-1:0]  days_q;
  logic [swcc_pkg::DszW-1:0]   dsyz_q;
  logic [swcc_pkg::TodW-1:0]   tod_q;
  logic [swcc_pkg::HourW-1:0]  hour_q;
  logic [swcc_pkg::MsW-1:0]    msr_q;
  logic [swcc_pkg::MinW-1:0]   min_q;
  logic [swcc_pkg::MinW-1:0]   sec_q;
  logic [swcc_pkg::YearW-1:0]  year_q;
  logic [6:0]                  mod100_q;
  logic [8:0]                  mod400_q;
  logic [swcc_pkg::MonthW-1:0] mon_q;
  logic                        leap;
  logic [8:0]                  year_len;
  logic [swcc_pkg::DayW-1:0]   mon_len;
  logic                        t_zero;

  assign cfg_i.ready = 1'b1;

  // configuration register and sync state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= swcc_pkg::FreqReset;
      epoch_q     <= '0;
      tick_sync_q <= '0;
      synced_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        freq_q <= cfg_i.data;
      end
      if (cmd_i.load_item && !in_i.func) begin
        epoch_q     <= in_i.epoch_seconds;
        tick_sync_q <= in_i.tick_now;
        synced_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      tick_now_q <= in_i.tick_now;
    end
  end

  // elapsed ticks, wrapping at 32 bits
  assign dividend = tick_now_q - tick_sync_q;

  // one quotient bit per step, restoring
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvsr_q};
  assign ge      = (shifted >= {1'b0, dvsr_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvsr_d = dvsr_q;
    cnt_d  = cnt_q;
    if (cmd_i.div_start) begin
      rem_d  = '0;
      quo_d  = dividend;
      dvsr_d = freq_q;
      cnt_d  = '0;
    end else if (cmd_i.div_step) begin
      rem_d = ge ? diff[31:0] : shifted[31:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvsr_q <= dvsr_d;
  end

  // quotients by reciprocal multiply, remainders by multiply back and subtract
  assign day_prod  = {26'd0, t_q[31:7]} * {25'd0, swcc_pkg::DayRecip};
  assign day_back  = {16'd0, days_q} * {15'd0, swcc_pkg::SecsPerDay};
  assign day_rem   = t_q - day_back;
  assign hour_prod = {13'd0, tod_q[16:4]} * {12'd0, swcc_pkg::HourRecip};
  assign hour_back = {12'd0, hour_q} * {5'd0, swcc_pkg::SecsPerHour};
  assign hour_rem  = tod_q - hour_back;
  assign min_prod  = {10'd0, msr_q[11:2]} * {9'd0, swcc_pkg::MinRecip};
  assign min_back  = {6'd0, min_q} * {6'd0, swcc_pkg::SecsPerMin};
  assign min_rem   = msr_q - min_back;

  // leap rule from running year residues
  assign leap     = ((year_q[1:0] == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign year_len = leap ? swcc_pkg::DaysLeapYear : swcc_pkg::DaysCommonYear;
  assign mon_len  = swcc_pkg::month_days(mon_q, leap);

  // captures and calendar walk
  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      swcc_pkg::CAP_T: begin
        if (!synced_q) begin
          t_q <= '0;
        end else if (freq_q == '0) begin
          t_q <= epoch_q;
        end else begin
          t_q <= epoch_q + quo_q;
        end
      end
      swcc_pkg::CAP_DAY_Q: begin
        days_q <= day_prod[50:35];
      end
      swcc_pkg::CAP_DAY_R: begin
        tod_q    <= day_rem[swcc_pkg::TodW-1:0];
        dsyz_q   <= swcc_pkg::DszW'(days_q) + swcc_pkg::DaysToUnixEpoch;
        year_q   <= swcc_pkg::FirstYear;
        mod100_q <= swcc_pkg::FirstYearMod100;
        mod400_q <= swcc_pkg::FirstYearMod400;
        mon_q    <= '0;
      end
      swcc_pkg::CAP_HOUR_Q: begin
        hour_q <= hour_prod[25:21];
      end
      swcc_pkg::CAP_HOUR_R: begin
        msr_q <= hour_rem[swcc_pkg::MsW-1:0];
      end
      swcc_pkg::CAP_MIN_Q: begin
        min_q <= min_prod[19:14];
      end
      swcc_pkg::CAP_MIN_R: begin
        sec_q <= min_rem[swcc_pkg::MinW-1:0];
      end
      default: begin
      end
    endcase

    if (cmd_i.year_step) begin
      days_q   <= days_q - swcc_pkg::DaysW'(year_len);
      year_q   <= year_q + 1'b1;
      mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 1'b1;
      mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
    end

    if (cmd_i.month_step) begin
      days_q <= days_q - swcc_pkg::DaysW'(mon_len);
      mon_q  <= mon_q + 1'b1;
    end
  end

  // status back to the controller
  assign sts_o.div_last   = (cnt_q == swcc_pkg::DivLastStep);
  assign sts_o.year_done  = (days_q < swcc_pkg::DaysW'(year_len));
  assign sts_o.month_done = (days_q < swcc_pkg::DaysW'(mon_len));

  // result register, calendar fields forced to zero for time zero
  assign t_zero = (t_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.is_synced            <= synced_q;
      out_o.unix_seconds         <= t_q;
      out_o.year                 <= t_zero ? '0 : year_q;
      out_o.month                <= t_zero ? '0 : mon_q + 1'b1;
      out_o.day                  <= t_zero ? '0 : days_q[swcc_pkg::DayW-1:0] + 1'b1;
      out_o.hour                 <= t_zero ? '0 : hour_q;
      out_o.minute               <= t_zero ? '0 : min_q;
      out_o.second               <= t_zero ? '0 : sec_q;
      out_o.days_since_year_zero <= t_zero ? '0 : dsyz_q;
      out_o.seconds_of_day       <= t_zero ? '0 : tod_q;
    end
  end

endmodule

// ===== rtl/swcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swcc_ctrl
// Sequencer for the divide, the time split, the year and month passes and
// the output handshake.
// ----------------------------------------------------------------------------
module swcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  swcc_in_if.sink             in_i,
  swcc_out_if.source          out_o,
  output swcc_pkg::cmd_t      cmd_o,
  input  swcc_pkg::sts_t      sts_i
);

  swcc_pkg::swcc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // state and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_i.ready  = (state_q == swcc_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      load_item:  1'b0,
      div_start:  1'b0,
      div_step:   1'b0,
      cap:        swcc_pkg::CAP_NONE,
      year_step:  1'b0,
      month_step: 1'b0,
      out_load:   1'b0
    };

    unique case (state_q)
      swcc_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          cmd_o.load_item = 1'b1;
          state_d         = swcc_pkg::ST_SEC_START;
        end
      end
      swcc_pkg::ST_SEC_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = swcc_pkg::ST_SEC_RUN;
      end
      swcc_pkg::ST_SEC_RUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = swcc_pkg::ST_T_CAP;
        end
      end
      swcc_pkg::ST_T_CAP: begin
        cmd_o.cap = swcc_pkg::CAP_T;
        state_d   = swcc_pkg::ST_DAY_QUO;
      end
      swcc_pkg::ST_DAY_QUO: begin
        cmd_o.cap = swcc_pkg::CAP_DAY_Q;
        state_d   = swcc_pkg::ST_DAY_REM;
      end
      swcc_pkg::ST_DAY_REM: begin
        cmd_o.cap = swcc_pkg::CAP_DAY_R;
        state_d   = swcc_pkg::ST_HOUR_QUO;
      end
      swcc_pkg::ST_HOUR_QUO: begin
        cmd_o.cap = swcc_pkg::CAP_HOUR_Q;
        state_d   = swcc_pkg::ST_HOUR_REM;
      end
      swcc_pkg::ST_HOUR_REM: begin
        cmd_o.cap = swcc_pkg::CAP_HOUR_R;
        state_d   = swcc_pkg::ST_MIN_QUO;
      end
      swcc_pkg::ST_MIN_QUO: begin
        cmd_o.cap = swcc_pkg::CAP_MIN_Q;
        state_d   = swcc_pkg::ST_MIN_REM;
      end
      swcc_pkg::ST_MIN_REM: begin
        cmd_o.cap = swcc_pkg::CAP_MIN_R;
        state_d   = swcc_pkg::ST_YEAR;
      end
      swcc_pkg::ST_YEAR: begin
        if (sts_i.year_done) begin
          state_d = swcc_pkg::ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      swcc_pkg::ST_MONTH: begin
        if (sts_i.month_done) begin
          state_d = swcc_pkg::ST_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      swcc_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          cmd_o.out_load = 1'b1;
          state_d        = swcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swcc_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat held until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

// ===== rtl/synced_wall_clock_calendar_core.sv =====
// ----------------------------------------------------------------------------
// synced_wall_clock_calendar_core
// Wall clock set by time sync beats, reporting Unix time and calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : item beats. func 0 syncs the clock to epoch_seconds at tick_now,
//           func 1 queries the time at tick_now. Every beat gives one result.
//   cfg_i : writes the tick frequency (ticks per second, reset 1000); write
//           only while no item is in flight. Always ready.
//   out_o : result beats with the Unix time and its Gregorian breakdown.
// Sequencing:
//   one item at a time; the core is ready for the next item the cycle
//   after the result is loaded into the output register. A 32-step
//   one-bit-per-cycle divide of elapsed ticks by the frequency comes first,
//   then the day, hour and minute quotient and remainder states split the
//   time by reciprocal multiplies into days, hours, minutes and seconds;
//   the year walker takes one step per whole year since 1970 and the month
//   walker one step per month before the result's month, one step per cycle.
// Reset:
//   unsynced, frequency 1000, no result pending; ready to accept at once.
// Stall:
//   a finished result sits in the output register while the next item is
//   accepted; that item's result waits until the held beat is taken.
// ----------------------------------------------------------------------------
module synced_wall_clock_calendar_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  swcc_in_if.sink    in_i,
  swcc_cfg_if.sink   cfg_i,
  swcc_out_if.source out_o
);

  swcc_pkg::cmd_t cmd;
  swcc_pkg::sts_t sts;

  // sequencer
  swcc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // arithmetic and storage
  swcc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ===== tb/sv/synced_wall_clock_calendar_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synced_wall_clock_calendar_core_tb
// Checks the synced wall clock against a behavioral calendar predictor. A
// queue of planned beats feeds a falling-edge driver. A rising-edge monitor
// predicts each accepted item, then compares every result beat field by
// field. The run steps through several tick frequencies, each written while
// the core is idle.
// ----------------------------------------------------------------------------
module synced_wall_clock_calendar_core_tb;

  localparam int unsigned DaySecs         = 86400;
  localparam int unsigned HourSecs        = 3600;
  localparam int unsigned DaysBeforeEpoch = 719528;
  localparam int unsigned EpochYear       = 1970;
  localparam int unsigned MonthLen [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WatchdogLimit   = 4000;
  localparam int unsigned TailCycles      = 400;
  localparam int unsigned PhaseItems      = 218;

  typedef enum logic {
    FUNC_SYNC  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_FREQ,
    OP_DRAIN,
    OP_PACE
  } op_kind_e;

  typedef struct {
    op_kind_e    kind;
    func_e       func;
    logic [31:0] epoch;
    logic [31:0] tick;
    logic [31:0] value;
    int unsigned gap_pct;
    int unsigned stall_pct;
  } beat_op_t;

  typedef struct packed {
    logic                       is_synced;
    logic [swcc_pkg::WordW-1:0]  unix_seconds;
    logic [swcc_pkg::YearW-1:0]  year;
    logic [swcc_pkg::MonthW-1:0] month;
    logic [swcc_pkg::DayW-1:0]   day;
    logic [swcc_pkg::HourW-1:0]  hour;
    logic [swcc_pkg::MinW-1:0]   minute;
    logic [swcc_pkg::MinW-1:0]   second;
    logic [swcc_pkg::DszW-1:0]   days_since_year_zero;
    logic [swcc_pkg::TodW-1:0]   seconds_of_day;
  } cal_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  swcc_in_if  in_if ();
  swcc_cfg_if cfg_if ();
  swcc_out_if out_if ();

  synced_wall_clock_calendar_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: frequency register plus sync point
  logic [31:0] tick_freq = 32'd1000;
  logic [31:0] sync_epoch = '0;
  logic [31:0] sync_tick = '0;
  logic        synced = 1'b0;

  beat_op_t    pending_beats[$];
  cal_result_t expected_dates[$];

  int unsigned in_sent, in_taken, cfg_sent, cfg_taken;
  int unsigned gap_left, stall_left, gap_pct, stall_pct;
  logic        draining;
  int unsigned mismatches, results_seen, quiet_cycles;

  function automatic int unsigned days_in_year(input int unsigned y);
    return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    return (m == 1 && days_in_year(y) == 366) ? 29 : MonthLen[m];
  endfunction

  // apply one item to the clock state and break the current time down
  function automatic cal_result_t calendar_after_beat(input func_e fn, input logic [31:0] epoch,
                                                      input logic [31:0] tick);
    cal_result_t r;
    logic [31:0] now_s;
    logic [31:0] elapsed;
    int unsigned days, tod, yr, mo;
    r = '0;
    now_s = '0;
    if (fn == FUNC_SYNC) begin
      sync_epoch = epoch;
      sync_tick = tick;
      synced = 1'b1;
    end
    // elapsed ticks wrap at 32 bits, a zero frequency adds nothing
    if (synced) begin
      elapsed = tick - sync_tick;
      now_s = sync_epoch;
      if (tick_freq != 0) now_s = sync_epoch + elapsed / tick_freq;
    end
    r.is_synced = synced;
    r.unix_seconds = now_s;
    if (now_s != 0) begin
      days = now_s / DaySecs;
      tod = now_s % DaySecs;
      r.days_since_year_zero = swcc_pkg::DszW'(days + DaysBeforeEpoch);
      r.seconds_of_day = swcc_pkg::TodW'(tod);
      r.hour = swcc_pkg::HourW'(tod / HourSecs);
      r.minute = swcc_pkg::MinW'((tod % HourSecs) / 60);
      r.second = swcc_pkg::MinW'(tod % 60);
      // walk whole years, then whole months
      yr = EpochYear;
      while (days >= days_in_year(yr)) begin
        days -= days_in_year(yr);
        yr++;
      end
      mo = 0;
      while (mo < 11 && days >= days_in_month(mo, yr)) begin
        days -= days_in_month(mo, yr);
        mo++;
      end
      r.year = swcc_pkg::YearW'(yr);
      r.month = swcc_pkg::MonthW'(mo + 1);
      r.day = swcc_pkg::DayW'(days + 1);
    end
    return r;
  endfunction

  function automatic void note_field(input string name, input longint unsigned want,
                                     input longint unsigned got, inout string diffs);
    if (want != got) diffs = {diffs, $sformatf(" %s exp %0d got %0d", name, want, got)};
  endfunction

  function automatic void push_item(input func_e fn, input logic [31:0] epoch,
                                    input logic [31:0] tick);
    beat_op_t op;
    op.kind = OP_ITEM;
    op.func = fn;
    op.epoch = epoch;
    op.tick = tick;
    pending_beats.push_back(op);
  endfunction

  // the frequency is only written once every result is back
  function automatic void push_freq(input logic [31:0] value);
    beat_op_t op;
    op.kind = OP_DRAIN;
    pending_beats.push_back(op);
    op.kind = OP_FREQ;
    op.value = value;
    pending_beats.push_back(op);
  endfunction

  function automatic void push_pace(input int unsigned gap, input int unsigned stall);
    beat_op_t op;
    op.kind = OP_PACE;
    op.gap_pct = gap;
    op.stall_pct = stall;
    pending_beats.push_back(op);
  endfunction

  // driver: item and frequency beats, result backpressure
  always @(negedge clk_i) begin
    beat_op_t op;
    logic in_v, cfg_v, rdy;
    if (rst_ni) begin
      in_v = in_if.valid && (in_sent != in_taken);
      cfg_v = cfg_if.valid && (cfg_sent != cfg_taken);
      if (!in_v && !cfg_v) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (draining) begin
          draining = (expected_dates.size() != 0);
        end else if (pending_beats.size() != 0) begin
          op = pending_beats.pop_front();
          case (op.kind)
            OP_ITEM: begin
              in_if.func <= op.func;
              in_if.epoch_seconds <= op.epoch;
              in_if.tick_now <= op.tick;
              in_v = 1'b1;
              in_sent++;
              if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 12);
            end
            OP_FREQ: begin
              cfg_if.data <= op.value;
              cfg_v = 1'b1;
              cfg_sent++;
            end
            OP_DRAIN: draining = 1'b1;
            default: begin
              gap_pct = op.gap_pct;
              stall_pct = op.stall_pct;
            end
          endcase
        end
      end
      // result side stalls in bursts
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
      end
      in_if.valid <= in_v;
      cfg_if.valid <= cfg_v;
      out_if.ready <= rdy;
    end
  end

  // monitor: predict on accept, compare on result, watch for a hang
  always @(posedge clk_i) begin
    cal_result_t got, want;
    string diffs;
    logic moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        tick_freq = cfg_if.data;
        cfg_taken++;
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        expected_dates.push_back(calendar_after_beat(func_e'(in_if.func), in_if.epoch_seconds,
                                                     in_if.tick_now));
        in_taken++;
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        results_seen++;
        got.is_synced = out_if.is_synced;
        got.unix_seconds = out_if.unix_seconds;
        got.year = out_if.year;
        got.month = out_if.month;
        got.day = out_if.day;
        got.hour = out_if.hour;
        got.minute = out_if.minute;
        got.second = out_if.second;
        got.days_since_year_zero = out_if.days_since_year_zero;
        got.seconds_of_day = out_if.seconds_of_day;
        if (expected_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: unix %0d", results_seen,
                     got.unix_seconds);
        end else begin
          want = expected_dates.pop_front();
          diffs = "";
          note_field("is_synced", want.is_synced, got.is_synced, diffs);
          note_field("unix_seconds", want.unix_seconds, got.unix_seconds, diffs);
          note_field("year", want.year, got.year, diffs);
          note_field("month", want.month, got.month, diffs);
          note_field("day", want.day, got.day, diffs);
          note_field("hour", want.hour, got.hour, diffs);
          note_field("minute", want.minute, got.minute, diffs);
          note_field("second", want.second, got.second, diffs);
          note_field("days_since_year_zero", want.days_since_year_zero,
                     got.days_since_year_zero, diffs);
          note_field("seconds_of_day", want.seconds_of_day, got.seconds_of_day, diffs);
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d mismatch:%s", results_seen, diffs);
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    logic [31:0] plan_freq [8];
    logic [31:0] tick_run, tick, epoch;
    func_e       fn;
    int unsigned sel;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_SYNC;
    in_if.epoch_seconds = '0;
    in_if.tick_now = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    in_sent = 0;
    in_taken = 0;
    cfg_sent = 0;
    cfg_taken = 0;
    gap_left = 0;
    stall_left = 0;
    gap_pct = 0;
    stall_pct = 0;
    draining = 1'b0;
    mismatches = 0;
    results_seen = 0;
    quiet_cycles = 0;

    // directed, reset frequency of 1000: unsynced queries, zero time, wraps
    push_item(FUNC_QUERY, 32'hFFFF_FFFF, 32'h0);
    push_item(FUNC_QUERY, 32'h0, 32'hFFFF_FFFF);
    push_item(FUNC_SYNC, 32'h0, 32'h0);
    push_item(FUNC_QUERY, 32'h0, 32'd999);
    push_item(FUNC_QUERY, 32'h0, 32'd1000);
    push_item(FUNC_SYNC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // tick difference wraps, then the time itself wraps to zero
    push_item(FUNC_QUERY, 32'h0, 32'd999);
    push_item(FUNC_QUERY, 32'h0, 32'd2999);
    // leap day 2000, new year's eve 1999, end of february 2100
    push_item(FUNC_SYNC, 32'd951782400, 32'd12345);
    push_item(FUNC_SYNC, 32'd946684799, 32'd0);
    push_item(FUNC_SYNC, 32'd4107542399, 32'd0);
    push_item(FUNC_QUERY, 32'h0, 32'd1000);
    push_item(FUNC_SYNC, 32'd86399, 32'd7);
    push_item(FUNC_QUERY, 32'h0, 32'hFFFF_FFFF);
    // zero frequency keeps the clock at the sync point
    push_freq(32'd0);
    push_item(FUNC_SYNC, 32'd1234567890, 32'd5);
    push_item(FUNC_QUERY, 32'h0, 32'hFFFF_FFFF);
    // one tick per second
    push_freq(32'd1);
    push_item(FUNC_SYNC, 32'hFFFF_FF00, 32'h0);
    push_item(FUNC_QUERY, 32'h0, 32'h0000_00FF);
    push_item(FUNC_QUERY, 32'h0, 32'h0000_0100);
    push_item(FUNC_QUERY, 32'h0, 32'h0000_0101);
    // largest frequency
    push_freq(32'hFFFF_FFFF);
    push_item(FUNC_SYNC, 32'd1000000000, 32'd1);
    push_item(FUNC_QUERY, 32'h0, 32'h0);
    push_item(FUNC_QUERY, 32'h0, 32'hFFFF_FFFF);

    // random phases, each at its own frequency and pace
    plan_freq = '{32'd1000, 32'd32768, 32'd1, 32'd0, 32'hFFFF_FFFF, $urandom,
                  32'd1000000, 32'd1000};
    tick_run = $urandom;
    for (int p = 0; p < 8; p++) begin
      push_freq(plan_freq[p]);
      if (p == 2 || p == 7) push_pace(0, 0);
      else push_pace($urandom_range(5, 60), $urandom_range(2, 20));
      for (int i = 0; i < PhaseItems; i++) begin
        // in phase 3 the sender waits out every result once mid-phase
        if (p == 3 && i == PhaseItems / 2) push_freq(plan_freq[p]);
        sel = $urandom_range(0, 99);
        if (sel < 60) tick_run += $urandom_range(0, 5000);
        else if (sel < 85) tick_run += $urandom_range(0, 32'h00FF_FFFF);
        else tick_run += $urandom;
        tick = tick_run;
        fn = ($urandom_range(0, 99) < 20) ? FUNC_SYNC : FUNC_QUERY;
        epoch = $urandom;
        // a little noise: tick jumps anywhere
        if ($urandom_range(0, 99) < 4) tick = $urandom;
        if (fn == FUNC_SYNC) begin
          case ($urandom_range(0, 4))
            0: epoch = $urandom;
            1: epoch = $urandom_range(32'h5000_0000, 32'h8000_0000);
            2: epoch = $urandom_range(0, 49710) * DaySecs +
                       ($urandom_range(0, 1) ? DaySecs - 1 : 0);
            3: epoch = $urandom_range(0, 200);
            default: epoch = 32'hFFFF_FFFF - $urandom_range(0, 100000);
          endcase
        end
        push_item(fn, epoch, tick);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain everything, then allow the core to settle
    while (pending_beats.size() != 0 || in_sent != in_taken || cfg_sent != cfg_taken ||
           expected_dates.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (expected_dates.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_dates.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== synced_wall_clock_calendar_core.f =====
rtl/swcc_pkg.sv
rtl/swcc_ifs.sv
rtl/swcc_datapath.sv
rtl/swcc_ctrl.sv
rtl/synced_wall_clock_calendar_core.sv
tb/sv/synced_wall_clock_calendar_core_tb.sv
